/* design/mialu_pkg.sv */
// Package for the multicycle integer ALU: data width, operation codes,
// sequencer states and the control bundle. No dependencies.
`timescale 1ns / 1ps

package mialu_pkg;

    // Operand and result width.
    localparam int DATA_WIDTH = 32;
    // Counter width that can hold the largest step count.
    localparam int CNT_W = $clog2(DATA_WIDTH + 1);

    typedef logic [CNT_W-1:0] t_cnt;

    // Operation codes carried in the kind field.
    typedef enum logic [2:0] {
        KIND_ADD  = 3'd0,
        KIND_SUB  = 3'd1,
        KIND_MUL  = 3'd2,
        KIND_QUO  = 3'd3,
        KIND_REM  = 3'd4,
        KIND_SQRT = 3'd5
    } t_kind;

    // Sequencer states.
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_FIN,
        ST_DONE
    } t_state;

    // Strobes from the sequencer to the datapath.
    typedef struct packed {
        logic load;
        logic step;
        logic finish;
    } t_ctrl;

    // Number of shared-unit iterations an operation needs.
    function automatic t_cnt steps_for(input t_kind kind);
        t_cnt n;
        case (kind)
            KIND_MUL, KIND_QUO, KIND_REM: n = t_cnt'(DATA_WIDTH);
            KIND_SQRT:                    n = t_cnt'(DATA_WIDTH / 2);
            default:                      n = t_cnt'(1);
        endcase
        return n;
    endfunction

endpackage

/* design/mialu_if.sv */
// Valid/ready channel interfaces for the multicycle integer ALU.
// Depends on mialu_pkg for the data width.
`timescale 1ns / 1ps

// Input channel: operation kind and two operands.
interface mialu_in_if;
    logic                            valid;
    logic                            ready;
    logic [2:0]                      kind;
    logic [mialu_pkg::DATA_WIDTH-1:0] operand_a;
    logic [mialu_pkg::DATA_WIDTH-1:0] operand_b;

    modport source (output valid, kind, operand_a, operand_b, input ready);
    modport sink   (input valid, kind, operand_a, operand_b, output ready);
endinterface

// Output channel: result value and divide-by-zero flag.
interface mialu_out_if;
    logic                            valid;
    logic                            ready;
    logic [mialu_pkg::DATA_WIDTH-1:0] result_value;
    logic                            divide_by_zero;

    modport source (output valid, result_value, divide_by_zero, input ready);
    modport sink   (input valid, result_value, divide_by_zero, output ready);
endinterface

/* design/multicycle_integer_alu_unit.sv */
// Top level of the multicycle integer ALU: sequencer plus shared datapath.
// After accept the sequencer runs the shared datapath for the step count of the operation,
// then passes the finish state and holds the result valid until it is taken.
// One transaction at a time: the next is taken no earlier than the cycle after the result.
// Reset (synchronous, active low) returns the sequencer to idle; data registers keep.
`timescale 1ns / 1ps

module multicycle_integer_alu_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    mialu_in_if.sink    i_in,
    mialu_out_if.source o_out
);

    mialu_pkg::t_ctrl ctrl;

    // Sequencer.
    mialu_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .i_kind      (i_in.kind),
        .i_out_ready (o_out.ready),
        .o_in_ready  (i_in.ready),
        .o_out_valid (o_out.valid),
        .o_ctrl      (ctrl)
    );

    // Shared arithmetic datapath.
    mialu_datapath u_datapath (
        .i_clk            (i_clk),
        .i_ctrl           (ctrl),
        .i_kind           (i_in.kind),
        .i_operand_a      (i_in.operand_a),
        .i_operand_b      (i_in.operand_b),
        .o_result_value   (o_out.result_value),
        .o_divide_by_zero (o_out.divide_by_zero)
    );

    // A pending result blocks new transactions.
    a_busy_when_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid |-> !i_in.ready)
        else $error("input ready while a result is pending");

    // An accepted transaction keeps the unit busy in the next cycle.
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in.valid && i_in.ready) |=> (!i_in.ready && !o_out.valid))
        else $error("unit not busy after accepting a transaction");

    // Once the result is taken the unit is ready again.
    a_ready_after_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.ready) |=> (i_in.ready && !o_out.valid))
        else $error("unit not idle after delivering a result");

endmodule

/* design/mialu_ctrl.sv */
// Sequencer of the multicycle integer ALU: handshakes and step counter.
// Depends on mialu_pkg.
`timescale 1ns / 1ps

module mialu_ctrl (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    input  logic [2:0]           i_kind,
    input  logic                 i_out_ready,
    output logic                 o_in_ready,
    output logic                 o_out_valid,
    output mialu_pkg::t_ctrl     o_ctrl
);

    mialu_pkg::t_state r_state, n_state;
    mialu_pkg::t_cnt   r_cnt, n_cnt;
    logic              accept;

    assign accept = i_in_valid && (r_state == mialu_pkg::ST_IDLE);

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            mialu_pkg::ST_IDLE: if (i_in_valid) n_state = mialu_pkg::ST_RUN;
            mialu_pkg::ST_RUN:  if (r_cnt == mialu_pkg::t_cnt'(1)) n_state = mialu_pkg::ST_FIN;
            mialu_pkg::ST_FIN:  n_state = mialu_pkg::ST_DONE;
            mialu_pkg::ST_DONE: if (i_out_ready) n_state = mialu_pkg::ST_IDLE;
            default:            n_state = mialu_pkg::ST_IDLE;
        endcase
    end

    // Step counter: loaded on accept, counts down while running.
    always_comb begin
        n_cnt = r_cnt;
        if (accept) begin
            n_cnt = mialu_pkg::steps_for(mialu_pkg::t_kind'(i_kind));
        end else if (r_state == mialu_pkg::ST_RUN) begin
            n_cnt = r_cnt - mialu_pkg::t_cnt'(1);
        end
    end

    // Outputs decoded from the state.
    always_comb begin
        o_in_ready    = (r_state == mialu_pkg::ST_IDLE);
        o_out_valid   = (r_state == mialu_pkg::ST_DONE);
        o_ctrl.load   = accept;
        o_ctrl.step   = (r_state == mialu_pkg::ST_RUN);
        o_ctrl.finish = (r_state == mialu_pkg::ST_FIN);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= mialu_pkg::ST_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

endmodule

/* design/mialu_datapath.sv */
// Datapath of the multicycle integer ALU: operand registers and one shared
// add/subtract unit used for add, shift-add multiply, restoring divide and
// digit-by-digit square root. Depends on mialu_pkg.
`timescale 1ns / 1ps

module mialu_datapath (
    input  logic                             i_clk,
    input  mialu_pkg::t_ctrl                 i_ctrl,
    input  logic [2:0]                       i_kind,
    input  logic [mialu_pkg::DATA_WIDTH-1:0] i_operand_a,
    input  logic [mialu_pkg::DATA_WIDTH-1:0] i_operand_b,
    output logic [mialu_pkg::DATA_WIDTH-1:0] o_result_value,
    output logic                             o_divide_by_zero
);

    localparam int W = mialu_pkg::DATA_WIDTH;

    mialu_pkg::t_kind r_kind, n_kind;
    // Operand a, then the quotient or the square root source as it shifts.
    logic [W-1:0] r_x, n_x;
    // Operand b (divisor, multiplier) or the square root being built.
    logic [W-1:0] r_y, n_y;
    // Partial remainder, product or sum.
    logic [W:0]   r_acc, n_acc;
    logic         r_zero_div, n_zero_div;
    logic [W-1:0] r_result, n_result;
    logic         r_dbz, n_dbz;

    // Shared unit operands and result.
    logic [W:0]   u_x, u_y;
    logic         u_sub;
    logic [W+1:0] u_res;
    logic         u_ge;

    // Shared add/subtract unit; in subtract mode the top bit is the borrow.
    assign u_res = u_sub ? ({1'b0, u_x} - {1'b0, u_y}) : ({1'b0, u_x} + {1'b0, u_y});
    assign u_ge  = !u_res[W+1];

    // Operand selection for one iteration of the current operation.
    always_comb begin
        u_x   = '0;
        u_y   = '0;
        u_sub = 1'b0;
        case (r_kind)
            mialu_pkg::KIND_ADD: begin
                u_x = {1'b0, r_x};
                u_y = {1'b0, r_y};
            end
            mialu_pkg::KIND_SUB: begin
                u_x   = {1'b0, r_x};
                u_y   = {1'b0, r_y};
                u_sub = 1'b1;
            end
            mialu_pkg::KIND_MUL: begin
                // Product doubles, then the multiplicand is added if the bit is set.
                u_x = {1'b0, r_acc[W-2:0], 1'b0};
                u_y = r_y[W-1] ? {1'b0, r_x} : '0;
            end
            mialu_pkg::KIND_QUO, mialu_pkg::KIND_REM: begin
                // Shift the next dividend bit into the partial remainder.
                u_x   = {r_acc[W-1:0], r_x[W-1]};
                u_y   = {1'b0, r_y};
                u_sub = 1'b1;
            end
            mialu_pkg::KIND_SQRT: begin
                // Bring down two bits; the trial value is four times root plus one.
                u_x   = {r_acc[W-2:0], r_x[W-1:W-2]};
                u_y   = {r_y[W-2:0], 2'b01};
                u_sub = 1'b1;
            end
            default: begin
                u_x = '0;
            end
        endcase
    end

    // Register updates on load, on each step and at the finish.
    always_comb begin
        n_kind     = r_kind;
        n_x        = r_x;
        n_y        = r_y;
        n_acc      = r_acc;
        n_zero_div = r_zero_div;
        n_result   = r_result;
        n_dbz      = r_dbz;
        if (i_ctrl.load) begin
            n_kind     = mialu_pkg::t_kind'(i_kind);
            n_x        = i_operand_a;
            n_y        = (i_kind == mialu_pkg::KIND_SQRT) ? '0 : i_operand_b;
            n_acc      = '0;
            n_zero_div = ((i_kind == mialu_pkg::KIND_QUO) || (i_kind == mialu_pkg::KIND_REM))
                         && (i_operand_b == '0);
        end else if (i_ctrl.step) begin
            case (r_kind)
                mialu_pkg::KIND_ADD, mialu_pkg::KIND_SUB: begin
                    n_acc = {1'b0, u_res[W-1:0]};
                end
                mialu_pkg::KIND_MUL: begin
                    n_acc = {1'b0, u_res[W-1:0]};
                    n_y   = {r_y[W-2:0], 1'b0};
                end
                mialu_pkg::KIND_QUO, mialu_pkg::KIND_REM: begin
                    // A zero divisor always subtracts, which leaves all ones and
                    // the dividend as the remainder.
                    n_acc = u_ge ? u_res[W:0] : u_x;
                    n_x   = {r_x[W-2:0], u_ge};
                end
                mialu_pkg::KIND_SQRT: begin
                    n_acc = u_ge ? u_res[W:0] : u_x;
                    n_y   = {r_y[W-2:0], u_ge};
                    n_x   = {r_x[W-3:0], 2'b00};
                end
                default: begin
                    n_acc = '0;
                end
            endcase
        end else if (i_ctrl.finish) begin
            n_dbz = r_zero_div;
            case (r_kind)
                mialu_pkg::KIND_ADD, mialu_pkg::KIND_SUB,
                mialu_pkg::KIND_MUL, mialu_pkg::KIND_REM: n_result = r_acc[W-1:0];
                mialu_pkg::KIND_QUO:                      n_result = r_x;
                mialu_pkg::KIND_SQRT:                     n_result = r_y;
                default:                                  n_result = '0;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        r_kind     <= n_kind;
        r_x        <= n_x;
        r_y        <= n_y;
        r_acc      <= n_acc;
        r_zero_div <= n_zero_div;
        r_result   <= n_result;
        r_dbz      <= n_dbz;
    end

    assign o_result_value   = r_result;
    assign o_divide_by_zero = r_dbz;

endmodule

/* sim/tb_multicycle_integer_alu_unit.sv */
// Self-checking testbench for multicycle_integer_alu_unit: directed corners, random
// operation mixes, full-rate streaming and output back-pressure, checked in order.
// Depends on mialu_pkg, mialu_if.sv and the unit's top-level module.
`timescale 1ns / 1ps

module tb_multicycle_integer_alu_unit;

    typedef logic [mialu_pkg::DATA_WIDTH-1:0] t_word;

    // Kind codes that the unit does not decode; they must produce a zero result.
    localparam logic [2:0] KIND_SPARE6 = 3'd6;
    localparam logic [2:0] KIND_SPARE7 = 3'd7;

    localparam int CLK_HALF_NS    = 2;
    localparam int RESET_CYCLES   = 10;
    localparam int IDLE_PERCENT   = 19;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int SETTLE_CYCLES  = 2 * (mialu_pkg::DATA_WIDTH + 2);
    localparam int MAX_REPORTS    = 10;
    localparam int OUT_STALL_LEN  = 300;

    // One pending result, kept with its operands for error messages.
    typedef struct {
        logic [2:0] kind;
        t_word      operand_a;
        t_word      operand_b;
        t_word      value;
        logic       divide_by_zero;
    } t_alu_op;

    logic i_clk;
    logic i_rst_n;

    mialu_in_if  in_ch ();
    mialu_out_if out_ch ();

    multicycle_integer_alu_unit dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    t_alu_op pending_results[$];
    t_alu_op oldest_result;
    int      error_count;
    int      quiet_cycles;
    bit      sender_idling;
    bit      receiver_idling;
    int      stall_request;
    int      stall_left;

    // Clock generation.
    initial begin
        i_clk = 1'b0;
        forever #(CLK_HALF_NS) i_clk = ~i_clk;
    end

    // Floor square root, built one root bit at a time from the top.
    function automatic t_word floor_sqrt(input t_word x);
        t_word                              root;
        t_word                              trial;
        logic [2*mialu_pkg::DATA_WIDTH-1:0] square;
        root = '0;
        for (int i = mialu_pkg::DATA_WIDTH / 2 - 1; i >= 0; i--) begin
            trial  = root | (t_word'(1) << i);
            square = trial * trial;
            if (square <= {{mialu_pkg::DATA_WIDTH{1'b0}}, x})
                root = trial;
        end
        return root;
    endfunction

    // Expected result of one operation.
    function automatic t_alu_op alu_compute(input logic [2:0] kind, input t_word a,
                                            input t_word b);
        t_alu_op r;
        r.kind           = kind;
        r.operand_a      = a;
        r.operand_b      = b;
        r.value          = '0;
        r.divide_by_zero = 1'b0;
        case (kind)
            mialu_pkg::KIND_ADD:  r.value = a + b;
            mialu_pkg::KIND_SUB:  r.value = a - b;
            mialu_pkg::KIND_MUL:  r.value = a * b;
            mialu_pkg::KIND_QUO: begin
                if (b == '0) begin
                    r.value          = '1;
                    r.divide_by_zero = 1'b1;
                end else begin
                    r.value = a / b;
                end
            end
            mialu_pkg::KIND_REM: begin
                if (b == '0) begin
                    r.value          = a;
                    r.divide_by_zero = 1'b1;
                end else begin
                    r.value = a % b;
                end
            end
            mialu_pkg::KIND_SQRT: r.value = floor_sqrt(a);
            default:              r.value = '0;
        endcase
        return r;
    endfunction

    // Operand with a bias toward the corners of the range.
    function automatic t_word rand_operand();
        t_word w;
        case ($urandom_range(5))
            0:       w = t_word'($urandom);
            1:       w = t_word'($urandom_range(255));
            2:       w = '1 - t_word'($urandom_range(255));
            3:       w = t_word'(1) << $urandom_range(mialu_pkg::DATA_WIDTH - 1);
            4:       w = $urandom_range(1) ? '1 : '0;
            default: w = t_word'($urandom) >> $urandom_range(mialu_pkg::DATA_WIDTH - 1);
        endcase
        return w;
    endfunction

    task automatic note_failure(input string msg);
        error_count++;
        if (error_count <= MAX_REPORTS)
            $display("[%0t] ERROR: %s", $time, msg);
    endtask

    // Offer one transaction and return once it is accepted; valid stays high
    // so that the next call can present its item without a gap.
    task automatic send_op(input logic [2:0] kind, input t_word a, input t_word b);
        @(negedge i_clk);
        while (sender_idling && $urandom_range(99) < IDLE_PERCENT) begin
            in_ch.valid     = 1'b0;
            in_ch.kind      = 3'($urandom);
            in_ch.operand_a = t_word'($urandom);
            in_ch.operand_b = t_word'($urandom);
            @(negedge i_clk);
        end
        in_ch.valid     = 1'b1;
        in_ch.kind      = kind;
        in_ch.operand_a = a;
        in_ch.operand_b = b;
        do
            @(posedge i_clk);
        while (!in_ch.ready);
        pending_results.push_back(alu_compute(kind, a, b));
    endtask

    // Lower valid and hold off until every pending result has come back.
    task automatic wait_all_results();
        @(negedge i_clk);
        in_ch.valid = 1'b0;
        while (pending_results.size() != 0)
            @(posedge i_clk);
    endtask

    task automatic send_random_op();
        logic [2:0] kind;
        t_word      a;
        t_word      b;
        t_word      r;
        if ($urandom_range(99) < 3)
            kind = $urandom_range(1) ? KIND_SPARE6 : KIND_SPARE7;
        else
            kind = 3'($urandom_range(5));
        a = rand_operand();
        b = rand_operand();
        // Square roots near perfect squares exercise the rounding boundary.
        if (kind == mialu_pkg::KIND_SQRT && $urandom_range(3) == 0) begin
            r = t_word'($urandom_range((1 << (mialu_pkg::DATA_WIDTH / 2)) - 1));
            a = r * r + t_word'($urandom_range(2)) - t_word'(1);
        end
        // Keep some zero divisors on the divide kinds.
        if ((kind == mialu_pkg::KIND_QUO || kind == mialu_pkg::KIND_REM) &&
            $urandom_range(15) == 0)
            b = '0;
        send_op(kind, a, b);
    endtask

    // Corners of every operation, including zero divisors and undecoded kinds.
    task automatic test_directed_corners();
        sender_idling   = 1'b0;
        receiver_idling = 1'b0;
        send_op(mialu_pkg::KIND_ADD,  '1, '1);
        send_op(mialu_pkg::KIND_ADD,  '0, '0);
        send_op(mialu_pkg::KIND_ADD,  '1, 32'd1);
        send_op(mialu_pkg::KIND_SUB,  '0, 32'd1);
        send_op(mialu_pkg::KIND_SUB,  '1, '1);
        send_op(mialu_pkg::KIND_SUB,  32'h5555_5555, 32'hAAAA_AAAA);
        send_op(mialu_pkg::KIND_MUL,  '1, '1);
        send_op(mialu_pkg::KIND_MUL,  32'h0001_0000, 32'h0001_0000);
        send_op(mialu_pkg::KIND_MUL,  32'h8000_0000, 32'd3);
        send_op(mialu_pkg::KIND_QUO,  '1, 32'd1);
        send_op(mialu_pkg::KIND_QUO,  32'd7, '0);
        send_op(mialu_pkg::KIND_QUO,  '0, '1);
        send_op(mialu_pkg::KIND_QUO,  32'd100, 32'd7);
        send_op(mialu_pkg::KIND_REM,  32'd5, '0);
        send_op(mialu_pkg::KIND_REM,  '1, '0);
        send_op(mialu_pkg::KIND_REM,  32'd100, 32'd7);
        send_op(mialu_pkg::KIND_SQRT, '0, '1);
        send_op(mialu_pkg::KIND_SQRT, 32'd1, '0);
        send_op(mialu_pkg::KIND_SQRT, '1, 32'h1234_5678);
        send_op(mialu_pkg::KIND_SQRT, 32'hFFFE_0001, '0);
        send_op(mialu_pkg::KIND_SQRT, 32'hFFFE_0000, '1);
        send_op(KIND_SPARE6, '1, '1);
        send_op(KIND_SPARE7, 32'd1, 32'd1);
        wait_all_results();
    endtask

    // Random operations with idle cycles on both channels.
    task automatic test_random_mix(input int count);
        sender_idling   = 1'b1;
        receiver_idling = 1'b1;
        repeat (count)
            send_random_op();
        wait_all_results();
    endtask

    // Back-to-back transactions with both channels always willing.
    task automatic test_full_rate_stream(input int count);
        sender_idling   = 1'b0;
        receiver_idling = 1'b0;
        repeat (count)
            send_random_op();
        wait_all_results();
    endtask

    // The output is held off for a long stretch while the input keeps offering,
    // so the unit fills up and must stall its input.
    task automatic test_output_stall(input int count);
        sender_idling   = 1'b0;
        receiver_idling = 1'b0;
        stall_request   = OUT_STALL_LEN;
        repeat (count)
            send_random_op();
        wait_all_results();
    endtask

    // Result sink: random idling and requested long holds, counted here.
    initial begin
        out_ch.ready = 1'b0;
        stall_left   = 0;
        forever begin
            @(negedge i_clk);
            if (stall_request != 0) begin
                stall_left    = stall_request;
                stall_request = 0;
            end
            if (stall_left > 0) begin
                stall_left--;
                out_ch.ready = 1'b0;
            end else if (receiver_idling && $urandom_range(99) < IDLE_PERCENT) begin
                out_ch.ready = 1'b0;
            end else begin
                out_ch.ready = 1'b1;
            end
        end
    end

    // Compare each result transaction with the oldest pending one.
    always @(posedge i_clk) begin
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            if (pending_results.size() == 0) begin
                note_failure($sformatf("unexpected result value=%h dbz=%b",
                                       out_ch.result_value, out_ch.divide_by_zero));
            end else begin
                oldest_result = pending_results.pop_front();
                if (out_ch.result_value !== oldest_result.value ||
                    out_ch.divide_by_zero !== oldest_result.divide_by_zero)
                    note_failure($sformatf(
                        "kind=%0d a=%h b=%h: expected value=%h dbz=%b, got value=%h dbz=%b",
                        oldest_result.kind, oldest_result.operand_a,
                        oldest_result.operand_b, oldest_result.value,
                        oldest_result.divide_by_zero, out_ch.result_value,
                        out_ch.divide_by_zero));
            end
        end
    end

    // Watchdog: too many cycles without a transaction on either channel.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("[%0t] ERROR: watchdog expired, %0d results pending",
                         $time, pending_results.size());
                $display("== FAIL ==");
                $finish;
            end
        end
    end

    // Test sequence.
    initial begin
        error_count     = 0;
        quiet_cycles    = 0;
        sender_idling   = 1'b0;
        receiver_idling = 1'b0;
        stall_request   = 0;
        i_rst_n         = 1'b0;
        in_ch.valid     = 1'b0;
        in_ch.kind      = mialu_pkg::KIND_ADD;
        in_ch.operand_a = '0;
        in_ch.operand_b = '0;
        repeat (RESET_CYCLES) @(negedge i_clk);
        i_rst_n = 1'b1;

        test_directed_corners();
        test_random_mix(700);
        test_output_stall(12);
        test_full_rate_stream(300);
        test_random_mix(400);
        test_output_stall(12);

        // Leave room for anything the unit might still emit.
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (error_count == 0 && pending_results.size() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

/* filelist.f */
design/mialu_pkg.sv
design/mialu_if.sv
design/mialu_ctrl.sv
design/mialu_datapath.sv
design/multicycle_integer_alu_unit.sv
sim/tb_multicycle_integer_alu_unit.sv
